[rtl/core/assert_macros.svh]
// assertion macros used by the console writer sequencer (tcw_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define TCW_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define TCW_ASSERT(lbl, clk, rst_n, prop, msg)

`define TCW_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

[rtl/core/tcw_pkg.sv]
// types, constants and helpers of the text console writer
`default_nettype none

package tcw_pkg;

	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int NCELLS = COLS * ROWS;
	localparam int ADDR_W = $clog2(NCELLS);

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int POS_W  = 11;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;

	localparam logic [1:0] OP_PUT    = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_SETCUR = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

	localparam logic [CHAR_W-1:0] COLOR_RST = 8'h0F;
	localparam logic [CELL_W-1:0] CELL_RST  = {COLOR_RST, CH_BLANK};

	typedef struct packed {
		logic [1:0]        opcode;
		logic [CHAR_W-1:0] char_code;
		logic [COL_W-1:0]  col_in;
		logic [ROW_W-1:0]  row_in;
	} in_word_t;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [POS_W-1:0]  cursor_pos;
		logic [CELL_W-1:0] cell_data;
	} out_word_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		int lin;
		lin = int'(r) * COLS + int'(c);
		return lin[ADDR_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] lin_pos(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		int lin;
		lin = int'(r) * COLS + int'(c);
		return lin[POS_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/core/text_console_writer_unit.sv]
// Text console writer: an 80x25 screen of 16-bit cells (attribute byte high,
// character low) and a cursor. A clear writes every cell, and a put that
// scrolls copies every row but the first one row up and then blanks the last
// row, cell by cell, since every cell passes through the single write port of
// the cell memory. After reset a clearing pass fills the screen with blanks;
// configuration writes are taken meanwhile, items are not. One word is handled
// at a time; the result register lets the next word in while a result still
// waits to be taken.
`default_nettype none

module text_console_writer_unit
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire in_word_t          in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output out_word_t              out_data,
	input  wire logic              cfg_we,
	input  wire logic [CHAR_W-1:0] cfg_wdata
);

	logic [CHAR_W-1:0] color_q;
	logic              out_valid_q;
	out_word_t         out_data_q;

	mem_req_t          mem_req;
	logic [CELL_W-1:0] mem_rdata;
	logic              res_valid;
	logic              res_ready;
	out_word_t         res_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RST;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	tcw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_data),
		.text_color (color_q),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_word   (res_word)
	);

	tcw_cell_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= res_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

[rtl/core/tcw_cell_store.sv]
// screen cell memory, one write and one registered read port
`default_nettype none

module tcw_cell_store
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_req_t          req,
	output logic      [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [NCELLS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/tcw_ctrl.sv]
// sequencer: cursor, character handling and memory sweeps
`default_nettype none

`include "assert_macros.svh"

module tcw_ctrl
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire in_word_t          in_word,
	input  wire logic [CHAR_W-1:0] text_color,
	output mem_req_t               mem_req,
	input  wire logic [CELL_W-1:0] mem_rdata,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output out_word_t              res_word
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RESP  = 3'd2;
	localparam logic [2:0] ST_CLEAR = 3'd3;
	localparam logic [2:0] ST_COPY  = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;
	localparam logic [2:0] ST_BLANK = 3'd6;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NCELLS - 1);
	localparam logic [ADDR_W-1:0] ROW1_ADDR = ADDR_W'(COLS);
	localparam logic [ADDR_W-1:0] LROW_ADDR = ADDR_W'(NCELLS - COLS);

	logic [2:0]         state_q;
	logic [COL_W-1:0]   cur_col_q;
	logic [ROW_W-1:0]   cur_row_q;
	logic [ADDR_W-1:0]  sweep_q;
	logic               hit_q;
	logic               pend_s1;
	logic [ADDR_W-1:0]  waddr_s1;

	logic               accept;
	logic               in_range;
	logic [CELL_W-1:0]  blank_cell;
	logic [COL_W:0]     put_col;
	logic [ROW_W:0]     put_row;
	logic               put_we;
	logic [ADDR_W-1:0]  put_addr;
	logic               put_scroll;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign in_range   = (int'(in_word.col_in) < COLS) && (int'(in_word.row_in) < ROWS);
	assign blank_cell = {text_color, CH_BLANK};

	always_comb begin
		put_col  = {1'b0, cur_col_q};
		put_row  = {1'b0, cur_row_q};
		put_we   = 1'b0;
		put_addr = cell_addr(cur_row_q, cur_col_q);
		unique case (in_word.char_code)
			CH_LF: begin
				put_col = '0;
				put_row = {1'b0, cur_row_q} + 1'b1;
			end
			CH_CR: begin
				put_col = '0;
			end
			CH_TAB: begin
				put_col = ({1'b0, cur_col_q} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
			end
			CH_BS: begin
				if (cur_col_q != '0) begin
					put_col  = {1'b0, cur_col_q} - 1'b1;
					put_we   = 1'b1;
					put_addr = cell_addr(cur_row_q, cur_col_q - 1'b1);
				end
			end
			default: begin
				put_we  = 1'b1;
				put_col = {1'b0, cur_col_q} + 1'b1;
			end
		endcase
		if (int'(put_col) >= COLS) begin
			put_col = '0;
			put_row = put_row + 1'b1;
		end
		put_scroll = (int'(put_row) >= ROWS);
		if (put_scroll) begin
			put_row = (ROW_W+1)'(ROWS - 1);
		end
	end

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = sweep_q;
				mem_req.wdata = CELL_RST;
			end
			ST_IDLE: begin
				if (accept && in_word.opcode == OP_PUT) begin
					mem_req.we    = put_we;
					mem_req.waddr = put_addr;
					mem_req.wdata = (in_word.char_code == CH_BS) ? blank_cell
					                                              : {text_color, in_word.char_code};
				end
				mem_req.re    = accept && (in_word.opcode == OP_READ) && in_range;
				mem_req.raddr = cell_addr(in_word.row_in, in_word.col_in);
			end
			ST_CLEAR, ST_BLANK: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = sweep_q;
				mem_req.wdata = blank_cell;
			end
			ST_COPY, ST_FLUSH: begin
				mem_req.we    = pend_s1;
				mem_req.waddr = waddr_s1;
				mem_req.wdata = mem_rdata;
				mem_req.re    = (state_q == ST_COPY);
				mem_req.raddr = sweep_q;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			cur_col_q <= '0;
			cur_row_q <= '0;
			sweep_q   <= '0;
			hit_q     <= 1'b0;
			pend_s1   <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_COPY);
			unique case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						hit_q <= (in_word.opcode == OP_READ) && in_range;
						unique case (in_word.opcode)
							OP_PUT: begin
								cur_col_q <= put_col[COL_W-1:0];
								cur_row_q <= put_row[ROW_W-1:0];
								if (put_scroll) begin
									sweep_q <= ROW1_ADDR;
									state_q <= ST_COPY;
								end else begin
									state_q <= ST_RESP;
								end
							end
							OP_CLEAR: begin
								cur_col_q <= '0;
								cur_row_q <= '0;
								sweep_q   <= '0;
								state_q   <= ST_CLEAR;
							end
							OP_SETCUR: begin
								if (in_range) begin
									cur_col_q <= in_word.col_in;
									cur_row_q <= in_word.row_in;
								end
								state_q <= ST_RESP;
							end
							OP_READ: begin
								state_q <= ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_ADDR) begin
						state_q <= ST_RESP;
					end
				end
				ST_COPY: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_ADDR) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					sweep_q <= LROW_ADDR;
					state_q <= ST_BLANK;
				end
				ST_BLANK: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_ADDR) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_COPY) begin
			waddr_s1 <= sweep_q - ROW1_ADDR;
		end
	end

	assign res_valid           = (state_q == ST_RESP);
	assign res_word.cursor_col = cur_col_q;
	assign res_word.cursor_row = cur_row_q;
	assign res_word.cursor_pos = lin_pos(cur_row_q, cur_col_q);
	assign res_word.cell_data  = hit_q ? mem_rdata : '0;

	`TCW_ASSERT(a_cursor_in_range, clk, arst_n, (state_q != ST_IDLE) || ((int'(cur_col_q) < COLS) && (int'(cur_row_q) < ROWS)), "cursor outside the screen while idle")
	`TCW_ASSERT_NEXT(a_copy_feeds_write, clk, arst_n, state_q == ST_COPY, pend_s1, "scroll copy lost a pending write")
	`TCW_ASSERT(a_blank_last_row, clk, arst_n, (state_q != ST_BLANK) || (sweep_q >= LROW_ADDR), "bottom row blanking outside the last row")
	`TCW_ASSERT(a_scroll_row, clk, arst_n, (state_q != ST_BLANK) || (int'(cur_row_q) == ROWS - 1), "cursor not on the last row during scroll")

endmodule

`default_nettype wire
